@@ hdl/tccs_pkg.sv @@
// ----------------------------------------------------------------------------
// tccs_pkg: shared types and constants of the text console cursor/scroll unit
// Item kinds, character codes, field widths and the control/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tccs_pkg;

    // default screen geometry
    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_ROWS_DEF    = 25;

    // stream payload widths
    localparam int IN_DATA_W  = 24;  // character, read_row, read_column
    localparam int IN_USER_W  = 2;   // kind
    localparam int OUT_DATA_W = 32;  // cell_value, cursor_row, cursor_column, scrolled
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;

    // item kinds
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // character codes and reset attribute
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h07;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_BLANK,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;       // item accepted this cycle
        logic copy;       // one step of the line-up copy pass
        logic blank;      // write one blank cell, advance the pass counter
        logic blank_rst;  // blank with the reset attribute (power-up pass)
        logic load_out;   // move the finished result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic take_scroll;  // the offered item scrolls the screen
        logic take_clear;   // the offered item clears the screen
        logic copy_end;     // copy pass at its last step
        logic blank_end;    // blank pass at its last cell
        logic out_free;     // output register can take a result
    } t_stat;

endpackage

@@ hdl/tccs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tccs_ctrl: sequencer of the text console
// Accepts one item at a time and steps the screen store through its
// copy and blank passes before handing the result to the output register.
// ----------------------------------------------------------------------------
module tccs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  tccs_pkg::t_stat i_stat,
    output tccs_pkg::t_cmd  o_cmd
);
    import tccs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.blank     = 1'b1;
                o_cmd.blank_rst = 1'b1;
                if (i_stat.blank_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.take_scroll) begin
                        n_state = ST_COPY;
                    end else if (i_stat.take_clear) begin
                        n_state = ST_BLANK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_stat.copy_end) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                o_cmd.blank = 1'b1;
                if (i_stat.blank_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // a pass never overlaps an accepted item
    a_take_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> !(o_cmd.copy || o_cmd.blank || o_cmd.load_out))
        else $error("item taken during a pass");

    // a scrolling item goes straight into the copy pass
    a_scroll_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_stat.take_scroll) |=> (r_state == ST_COPY))
        else $error("scroll did not start the copy pass");

    // the copy pass always hands over to the bottom-line blank pass
    a_copy_to_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.copy && i_stat.copy_end) |=> (r_state == ST_BLANK))
        else $error("copy pass did not end in blank pass");

endmodule

@@ hdl/tccs_dpath.sv @@
// ----------------------------------------------------------------------------
// tccs_dpath: screen store, cursor and result register of the text console
// Holds the cell memory with its single write and single read port, the
// cursor, the pass counter, the attribute register and the output register.
// ----------------------------------------------------------------------------
module tccs_dpath #(
    parameter int SCREEN_COLUMNS = tccs_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tccs_pkg::SCREEN_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tccs_pkg::t_cmd                  i_cmd,
    output tccs_pkg::t_stat                 o_stat,
    input  logic [tccs_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [tccs_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                            i_cfg_valid,
    input  logic [tccs_pkg::ATTR_W-1:0]     i_cfg_data,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [tccs_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import tccs_pkg::*;

    localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int COL_W      = $clog2(SCREEN_COLUMNS);

    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_q;

    logic [ADDR_W-1:0]     r_cnt;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;
    logic [ATTR_W-1:0]     r_attr;
    logic                  r_scrolled;
    logic                  r_cell_sel;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [1:0]        w_kind;
    logic [7:0]        w_char;
    logic [4:0]        w_rrow;
    logic [6:0]        w_rcol;
    logic              w_newline;
    logic              w_next_row;
    logic              w_row_end;
    logic              w_rd_ok;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [ADDR_W-1:0] w_rd_req_addr;

    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [CELL_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [CELL_W-1:0] w_cell;

    assign w_kind = i_s_tuser;
    assign w_char = i_s_tdata[7:0];
    assign w_rrow = i_s_tdata[12:8];
    assign w_rcol = i_s_tdata[19:13];

    assign w_newline  = (w_char == NEWLINE_CODE);
    assign w_row_end  = (r_row == ROW_LAST);
    assign w_next_row = w_newline || (r_col == COL_LAST);
    assign w_rd_ok    = (int'(w_rrow) < SCREEN_ROWS) && (int'(w_rcol) < SCREEN_COLUMNS);

    assign w_cur_addr    = ADDR_W'(r_row) * COLS_A + ADDR_W'(r_col);
    assign w_rd_req_addr = ADDR_W'(w_rrow) * COLS_A + ADDR_W'(w_rcol);

    assign o_stat.take_scroll = (w_kind == KIND_PUT) && w_next_row && w_row_end;
    assign o_stat.take_clear  = (w_kind == KIND_CLEAR);
    assign o_stat.copy_end    = (r_cnt == COPY_LAST);
    assign o_stat.blank_end   = (r_cnt == CELL_LAST);
    assign o_stat.out_free    = !r_out_valid || i_m_tready;

    // memory port selection
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cnt;
        w_wr_data = {r_attr, BLANK_CODE};
        w_rd_en   = 1'b0;
        w_rd_addr = r_cnt + COLS_A;
        if (i_cmd.take) begin
            if (w_kind == KIND_PUT && !w_newline) begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_cur_addr;
                w_wr_data = {r_attr, w_char};
            end
            if (w_kind == KIND_READ && w_rd_ok) begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_rd_req_addr;
            end
        end else if (i_cmd.copy) begin
            // write the cell read last step one line up, read the next one
            w_wr_en   = (r_cnt != '0);
            w_wr_addr = r_cnt - ADDR_W'(1);
            w_wr_data = r_q;
            w_rd_en   = (r_cnt != COPY_LAST);
        end else if (i_cmd.blank) begin
            w_wr_en   = 1'b1;
            w_wr_data = {(i_cmd.blank_rst ? ATTR_RESET : r_attr), BLANK_CODE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_q <= r_mem[w_rd_addr];
        end
    end

    // pass counter, cursor and attribute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_attr <= ATTR_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.copy && (r_cnt != COPY_LAST)) begin
                r_cnt <= r_cnt + ADDR_W'(1);
            end else if (i_cmd.blank) begin
                r_cnt <= (r_cnt == CELL_LAST) ? '0 : r_cnt + ADDR_W'(1);
            end
            if (i_cmd.take) begin
                if (w_kind == KIND_PUT) begin
                    if (w_next_row) begin
                        r_col <= '0;
                        if (!w_row_end) begin
                            r_row <= r_row + ROW_W'(1);
                        end
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end else if (w_kind == KIND_CLEAR) begin
                    r_row <= '0;
                    r_col <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_scrolled <= o_stat.take_scroll;
            r_cell_sel <= (w_kind == KIND_READ) && w_rd_ok;
        end
    end

    assign w_cell = r_cell_sel ? r_q : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {3'b000, r_scrolled, 7'(r_col), 5'(r_row), w_cell};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_row) < SCREEN_ROWS)
        else $error("cursor row beyond screen");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) < SCREEN_COLUMNS)
        else $error("cursor column beyond screen");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over an untaken one");

    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[28]) |-> (r_out_data[20:16] == 5'(SCREEN_ROWS - 1)))
        else $error("scrolled result not on last row");

endmodule

@@ hdl/text_console_cursor_scroll_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_unit: character-cell text console engine
// Screen store of rows x columns 16-bit cells with cursor, line wrap,
// newline, upward scroll, clear and single-cell read.
// ----------------------------------------------------------------------------
// The unit takes one item at a time on the slave stream (tuser = kind: put
// character, clear screen, read cell) and returns exactly one result per
// item on the master stream: the cell read, the cursor after the item and
// a scroll flag. The screen lives in one memory with one write and one
// read port, and that port pair sets the timing. A put character, a
// newline, a read or an unused kind is accepted and its result is then
// loaded into the output register. A put or newline that steps past the
// last row adds a copy pass that moves every line but the top one a line
// up and a blank pass over the bottom line. A clear adds a blank pass over
// every cell. After reset a clearing pass over every cell fills the screen
// with blanks of attribute 7; no item is accepted until it ends, while the
// attribute write channel is always ready. A finished result waits in the
// output register, and the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_unit #(
    parameter int SCREEN_COLUMNS = tccs_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tccs_pkg::SCREEN_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // attribute register write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tccs_pkg::ATTR_W-1:0]     i_cfg_data,     // text_attribute
    // item input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] character, [12:8] read_row, [19:13] read_column, [23:20] zero
    input  logic [tccs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [tccs_pkg::IN_USER_W-1:0]  s_axis_tuser,   // [1:0] kind
    // result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] cell_value, [20:16] cursor_row, [27:21] cursor_column,
    // [28] scrolled, [31:29] zero
    output logic [tccs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tccs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // attribute writes are to happen only while idle; the user is bound to this, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    tccs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tccs_dpath #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule
